FILE: design/tsoca_pkg.sv
// Package for the torque sensor offset calibration and moving average block.
// Holds widths, function codes, register indexes, the sequencer state type and
// divider status struct; depends on nothing.
`default_nettype none

package tsoca_pkg;

  // Sizing (WINDOW must be a power of two)
  localparam int WINDOW       = 8;
  localparam int WIN_BITS     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ADC_BITS     = 12;
  localparam int ADC_FULL     = (2 ** ADC_BITS) - 1;
  localparam int SAMPLE_BITS  = 12;
  localparam int GAIN_BITS    = 16;
  localparam int CENT_BITS    = ADC_BITS + 1;
  localparam int RAW_BITS     = CENT_BITS + GAIN_BITS + 1;
  localparam int V_BITS       = RAW_BITS + 1;
  localparam int WSUM_BITS    = V_BITS + $clog2(WINDOW);
  localparam int CNT_BITS     = 16;
  localparam int CAL_SUM_BITS = RAW_BITS + CNT_BITS;
  localparam int DIV_CNT_BITS = $clog2(CAL_SUM_BITS + 1);
  localparam int TORQUE_BITS  = 30;
  localparam int TORQUE_MAX   = (2 ** (TORQUE_BITS - 1)) - 1;
  localparam int TORQUE_MIN   = -(2 ** (TORQUE_BITS - 1));

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // Register indexes (word address bit 2)
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_SIGN = 1'b1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

  typedef enum logic [1:0] {
    FUNC_MEASURE = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_SAMPLE  = 2'd2,
    FUNC_END     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: design/torque_sensor_offset_calibrate_average.sv
// Top level of the torque sensor offset calibration and moving average block.
// Depends on tsoca_pkg and tsoca_div.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the ADC code in s_tdata and
//   the function code in s_tuser (measure, start calibration, calibration
//   sample, end calibration). Each item yields exactly one result item on
//   m_tvalid/m_tready: the moving average of calibrated torque in m_tdata
//   and the calibration-in-progress flag in m_tuser.
//   Each item passes from accept to the next accept through latch, the gain
//   multiplier, state update, and forming and registering the average. An
//   end of calibration with a nonzero sample count also runs the bit-serial
//   divider (one quotient bit per cycle over the 46-bit calibration sum).
//   s_tready is high only while the sequencer is idle. A finished result
//   sits in the output register; a new item may be taken while it waits,
//   but the sequencer holds in its final step until the receiver drains it.
//   Reset clears the window, offset, calibration sum and count, and sets
//   gain to 1.0 (Q8.8) and sign to positive. Write gain and sign through the
//   APB port only while no item is in flight.
`default_nettype none

module torque_sensor_offset_calibrate_average (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] func
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [29:0] torque, [31:30] zero
  output logic             m_tuser,   // [0] calibrating
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tsoca_pkg::*;

  // Configuration registers
  logic [GAIN_BITS-1:0] gain;
  logic                 sign_negative;

  // Sequencer
  state_t state, state_next;
  logic   div_start;
  logic   out_load;

  // Latched item
  func_t                   func;
  logic [SAMPLE_BITS-1:0]  sample;

  // Calibration and window state
  logic signed [RAW_BITS-1:0]     raw;
  logic signed [RAW_BITS-1:0]     offset;
  logic signed [CAL_SUM_BITS-1:0] cal_sum;
  logic [CNT_BITS-1:0]            cal_count;
  logic                           cal_active;
  logic signed [V_BITS-1:0]       window_store [WINDOW];
  logic signed [WSUM_BITS-1:0]    window_sum;
  logic [WIN_BITS-1:0]            wptr;

  // Combinational datapath
  logic signed [CENT_BITS:0]     cent_wide;
  logic signed [CENT_BITS-1:0]   cent;
  logic signed [CENT_BITS-1:0]   cent_s;
  logic signed [RAW_BITS-1:0]    prod;
  logic signed [V_BITS-1:0]      v;
  logic signed [WSUM_BITS-1:0]   wsum_next;
  logic signed [WSUM_BITS-1:0]   wbias;
  logic signed [WSUM_BITS-1:0]   wadj;
  logic signed [WSUM_BITS-1:0]   avg;
  logic [TORQUE_BITS-1:0]        torque_sat;

  div_status_t                   div_stat;
  logic signed [RAW_BITS-1:0]    div_q;

  logic cfg_write;

  // ---------------------------------------------------------------------
  // APB port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= GAIN_RESET;
      sign_negative <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_GAIN: gain          <= pwdata[GAIN_BITS-1:0];
        REG_SIGN: sign_negative <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN: prdata = {{(32-GAIN_BITS){1'b0}}, gain};
      REG_SIGN: prdata = {31'd0, sign_negative};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_EXEC;
      ST_EXEC: state_next = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_stat.done) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_EXEC) && (func == FUNC_END) && (cal_count != '0);
    out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Raw torque: centre the code, apply sign, scale by Q8.8 gain
  // ---------------------------------------------------------------------
  assign cent_wide = $signed({1'b0, sample[ADC_BITS-1:0], 1'b0})
                   - $signed((CENT_BITS+1)'(ADC_FULL));
  assign cent      = cent_wide[CENT_BITS-1:0];
  assign cent_s    = sign_negative ? -cent : cent;
  assign prod      = cent_s * $signed({1'b0, gain});

  // Window update terms
  assign v         = raw - offset;
  assign wsum_next = window_sum + v - window_store[wptr];

  // Average: divide by WINDOW truncating toward zero, then saturate
  assign wbias = window_sum[WSUM_BITS-1] ? WSUM_BITS'(WINDOW - 1) : '0;
  assign wadj  = window_sum + wbias;
  assign avg   = wadj >>> $clog2(WINDOW);

  always_comb begin
    if (avg > $signed(WSUM_BITS'(TORQUE_MAX))) begin
      torque_sat = TORQUE_BITS'(TORQUE_MAX);
    end else if (avg < $signed(WSUM_BITS'(TORQUE_MIN))) begin
      torque_sat = TORQUE_BITS'(TORQUE_MIN);
    end else begin
      torque_sat = avg[TORQUE_BITS-1:0];
    end
  end

  // Latch the item and the product
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func   <= func_t'(s_tuser);
      sample <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == ST_MUL) begin
      raw <= prod;
    end
  end

  // ---------------------------------------------------------------------
  // State update per function code
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      cal_sum    <= '0;
      cal_count  <= '0;
      cal_active <= 1'b0;
      window_sum <= '0;
      wptr       <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        window_store[i] <= '0;
      end
    end else begin
      if (state == ST_EXEC) begin
        case (func)
          FUNC_MEASURE: begin
            window_sum         <= wsum_next;
            window_store[wptr] <= v;
            wptr <= (wptr == WIN_BITS'(WINDOW - 1)) ? '0 : wptr + 1'b1;
          end
          FUNC_START: begin
            cal_sum    <= '0;
            cal_count  <= '0;
            cal_active <= 1'b1;
          end
          FUNC_SAMPLE: begin
            // hold sum and count once the count saturates
            if (cal_count != CNT_MAX) begin
              cal_sum   <= cal_sum + raw;
              cal_count <= cal_count + 1'b1;
            end
          end
          default: begin
            // empty calibration clears the offset; otherwise the divider loads it
            if (cal_count == '0) begin
              offset <= '0;
            end
            cal_active <= 1'b0;
          end
        endcase
      end
      if (state == ST_DIV && div_stat.done) begin
        offset <= div_q;
      end
    end
  end

  // Offset = cal_sum / cal_count
  tsoca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cal_sum),
    .divisor  (cal_count),
    .status   (div_stat),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(32-TORQUE_BITS){1'b0}}, torque_sat};
      m_tuser <= cal_active;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && func == FUNC_START) |=> (cal_count == '0 && cal_active))
    else $error("start of calibration did not clear the count");

  a_ptr_only_measure: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_EXEC && func == FUNC_MEASURE) |=> $stable(wptr))
    else $error("window pointer moved without a measure item");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !out_load)
    else $error("result loaded while the divider runs");
`endif

endmodule

`default_nettype wire

FILE: design/tsoca_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero. Depends on tsoca_pkg.
`default_nettype none

module tsoca_div (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  input  wire logic signed [tsoca_pkg::CAL_SUM_BITS-1:0] dividend,
  input  wire logic [tsoca_pkg::CNT_BITS-1:0]           divisor,
  output tsoca_pkg::div_status_t                        status,
  output logic signed [tsoca_pkg::RAW_BITS-1:0]         quotient
);
  import tsoca_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [CAL_SUM_BITS-1:0] acc;
  logic [CNT_BITS-1:0]     rem;
  logic [CNT_BITS-1:0]     dvs;
  logic                    neg;

  logic [CNT_BITS:0]       rem_shift;
  logic [CNT_BITS:0]       rem_diff;
  logic                    ge;
  logic [CAL_SUM_BITS-1:0] qmag;

  assign rem_shift = {rem, acc[CAL_SUM_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign ge        = (rem_shift >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(CAL_SUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend magnitude out, the quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[CAL_SUM_BITS-1];
      acc <= dividend[CAL_SUM_BITS-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_diff[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
      acc <= {acc[CAL_SUM_BITS-2:0], ge};
    end
  end

  assign qmag     = neg ? -acc : acc;
  assign quotient = $signed(qmag[RAW_BITS-1:0]);
  assign status   = '{busy: busy, done: done};

endmodule

`default_nettype wire

FILE: dv/torque_sensor_offset_calibrate_average_tb.sv
// Self-checking testbench for torque_sensor_offset_calibrate_average: drives items on the
// input stream and the APB port, and scores every result against its own predictor.
// Depends on tsoca_pkg and the block's RTL only.
`timescale 1ns / 1ps

module torque_sensor_offset_calibrate_average_tb;
  import tsoca_pkg::*;

  // APB byte addresses of the two registers
  localparam logic [2:0] ADDR_GAIN = {REG_GAIN, 2'b00};
  localparam logic [2:0] ADDR_SIGN = {REG_SIGN, 2'b00};

  localparam int PHASE_ITEMS = 186;
  localparam int N_PHASES    = 7;
  // Longest quiet stretch after the last result: divider plus pipeline
  localparam int TAIL_CYCLES = 64;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [11:0] sample, [15:12] zero
  logic [1:0]  s_tuser;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [29:0] torque, [31:30] zero
  logic        m_tuser;   // [0] calibrating
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  torque_sensor_offset_calibrate_average dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // One result item as the block should present it
  typedef struct packed {
    logic [TORQUE_BITS-1:0] torque;
    logic                   calibrating;
  } torque_out_t;

  // Directed row: typed marks a result worked out by hand
  typedef struct packed {
    func_t                         op;
    logic [ADC_BITS-1:0]           code;
    logic                          typed;
    logic signed [TORQUE_BITS-1:0] torque;
    logic                          cal;
  } row_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    logic                 rand_gain;
    logic                 negate;
    int                   src_pct;
    int                   sink_pct;
  } phase_t;

  // Predictor state, kept at the block's widths
  logic signed [V_BITS-1:0]       win_slot [WINDOW];
  logic signed [WSUM_BITS-1:0]    win_total;
  logic [WIN_BITS-1:0]            win_ptr;
  logic signed [TORQUE_BITS-1:0]  cal_offset;
  logic signed [CAL_SUM_BITS-1:0] cal_acc;
  logic [CNT_BITS-1:0]            cal_cnt;
  logic                           cal_on;
  logic [GAIN_BITS-1:0]           cfg_gain;
  logic                           cfg_negate;

  torque_out_t torque_due [$];
  torque_out_t seen_want;

  int src_idle_pct;
  int sink_stall_pct;
  int items_sent;
  int results_seen;
  int mismatches;
  int cals_ended;
  int settings_applied;

  // Directed opening, starting from the reset state (gain 1.0, sign positive).
  // The first rows are easy to check by hand: full-scale codes give
  // +/-4095*256, and the window average is that over eight.
  row_t plan [21] = '{
    // measure at the bottom code, then the top code: the window sums back to zero
    '{FUNC_MEASURE, 12'd0,    1'b1, -30'sd131040, 1'b0},
    '{FUNC_MEASURE, 12'd4095, 1'b1,  30'sd0,      1'b0},
    // end with no start and no samples: offset stays zero
    '{FUNC_END,     12'd100,  1'b1,  30'sd0,      1'b0},
    // calibration sample without a start still accumulates
    '{FUNC_SAMPLE,  12'd4095, 1'b1,  30'sd0,      1'b0},
    // end without a start loads offset = full scale
    '{FUNC_END,     12'd0,    1'b1,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd4095, 1'b1,  30'sd0,      1'b0},
    '{FUNC_START,   12'd7,    1'b1,  30'sd0,      1'b1},
    // measure during calibration uses the old offset
    '{FUNC_MEASURE, 12'd0,    1'b1, -30'sd262080, 1'b1},
    // three samples summing to -256: the offset truncates toward zero
    '{FUNC_SAMPLE,  12'd0,    1'b0,  30'sd0,      1'b0},
    '{FUNC_SAMPLE,  12'd4095, 1'b0,  30'sd0,      1'b0},
    '{FUNC_SAMPLE,  12'd2047, 1'b0,  30'sd0,      1'b0},
    '{FUNC_END,     12'd2048, 1'b0,  30'sd0,      1'b0},
    // negative window sum not a multiple of eight, then wrap the window
    '{FUNC_MEASURE, 12'd2047, 1'b0,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd4095, 1'b0,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd0,    1'b0,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd4095, 1'b0,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd2048, 1'b0,  30'sd0,      1'b0},
    '{FUNC_MEASURE, 12'd0,    1'b0,  30'sd0,      1'b0},
    '{FUNC_START,   12'd4095, 1'b0,  30'sd0,      1'b0},
    '{FUNC_SAMPLE,  12'd2048, 1'b0,  30'sd0,      1'b0},
    '{FUNC_END,     12'd1,    1'b0,  30'sd0,      1'b0}
  };

  // Register settings per random phase, extremes of gain and both signs;
  // idling: none, sender, receiver, both lightly
  phase_t phases [N_PHASES] = '{
    '{16'd256,   1'b0, 1'b0,  0,  0},
    '{16'd65535, 1'b0, 1'b1, 69,  0},
    '{16'd0,     1'b0, 1'b0,  0, 69},
    '{16'd1,     1'b0, 1'b1, 10, 10},
    '{16'd0,     1'b1, 1'b1,  0,  0},
    '{16'd65535, 1'b0, 1'b0, 69,  0},
    '{16'd0,     1'b1, 1'b0,  0, 69}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest correct run is well under a tenth of this
  initial begin
    #20_000_000;
    $display("FAIL torque_sensor_offset_calibrate_average");
    $finish;
  end

  // Advance the predictor by one accepted item and return the result it causes.
  function automatic torque_out_t predict_torque(func_t op, logic [ADC_BITS-1:0] code);
    longint      raw;
    longint      v;
    longint      avg;
    torque_out_t r;
    // centre the code around zero, apply sign, then the Q8.8 gain
    raw = 2 * longint'(code) - longint'(ADC_FULL);
    if (cfg_negate) raw = -raw;
    raw = raw * longint'(cfg_gain);
    case (op)
      FUNC_MEASURE: begin
        v = raw - longint'(cal_offset);
        win_total = WSUM_BITS'(longint'(win_total) + v - longint'(win_slot[win_ptr]));
        win_slot[win_ptr] = V_BITS'(v);
        win_ptr = win_ptr + 1'b1;
      end
      FUNC_START: begin
        cal_acc = '0;
        cal_cnt = '0;
        cal_on  = 1'b1;
      end
      FUNC_SAMPLE: begin
        // hold sum and count once the count is full
        if (cal_cnt != CNT_MAX) begin
          cal_acc = CAL_SUM_BITS'(longint'(cal_acc) + raw);
          cal_cnt = cal_cnt + 1'b1;
        end
      end
      FUNC_END: begin
        // empty calibration gives a zero offset; otherwise truncate toward zero
        cal_offset = TORQUE_BITS'((cal_cnt != '0) ?
                                  longint'(cal_acc) / longint'(cal_cnt) : longint'(0));
        cal_on = 1'b0;
        cals_ended++;
      end
    endcase
    avg = longint'(win_total) / longint'(WINDOW);
    if (avg > longint'(TORQUE_MAX)) avg = longint'(TORQUE_MAX);
    if (avg < longint'(TORQUE_MIN)) avg = longint'(TORQUE_MIN);
    r.torque      = avg[TORQUE_BITS-1:0];
    r.calibrating = cal_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Codes lean on the extremes and the mid-scale pair around zero.
  function automatic logic [ADC_BITS-1:0] pick_code();
    case ($urandom_range(9))
      0: return '0;
      1: return ADC_BITS'(ADC_FULL);
      2: return ADC_BITS'($urandom_range(2048, 2047));
      default: return ADC_BITS'($urandom_range(ADC_FULL));
    endcase
  endfunction

  // Present one item from a falling edge, hold it until accepted, and queue
  // what it should produce. Returns at a falling edge with tvalid still high.
  task automatic put_item(func_t op, logic [ADC_BITS-1:0] code, logic typed = 1'b0,
                          logic [TORQUE_BITS-1:0] t_torque = '0, logic t_cal = 1'b0);
    torque_out_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_torque(op, code);
    // hand-worked rows override the predictor's answer, which still advances
    if (typed) begin
      want.torque      = t_torque;
      want.calibrating = t_cal;
    end
    torque_due.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and wait for every queued result to drain.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (torque_due.size() != 0) @(negedge clk);
  endtask

  // One APB transfer; returns at a falling edge after the access, with the bus idle.
  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Write both registers while idle, mirror them in the predictor, read back.
  task automatic apply_settings(logic [GAIN_BITS-1:0] gain, logic negate);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_GAIN, {16'b0, gain}, rd);
    apb_access(1'b1, ADDR_SIGN, {31'b0, negate}, rd);
    cfg_gain   = gain;
    cfg_negate = negate;
    apb_access(1'b0, ADDR_GAIN, '0, rd);
    if (rd[GAIN_BITS-1:0] !== gain) report_mismatch("gain read-back", gain, rd[GAIN_BITS-1:0]);
    apb_access(1'b0, ADDR_SIGN, '0, rd);
    if (rd[0] !== negate) report_mismatch("sign read-back", negate, rd[0]);
    settings_applied++;
  endtask

  // Mostly well-formed calibrations and measures with random content,
  // the rest stray function codes.
  task automatic run_random(int n);
    int stop_at;
    int k;
    int pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        put_item(FUNC_MEASURE, pick_code());
      end else if (pick < 85) begin
        put_item(FUNC_START, pick_code());
        k = $urandom_range(12, 1);
        for (int j = 0; j < k; j++) begin
          if ($urandom_range(99) < 15) put_item(FUNC_MEASURE, pick_code());
          put_item(FUNC_SAMPLE, pick_code());
        end
        put_item(FUNC_END, pick_code());
      end else begin
        put_item(func_t'($urandom_range(3)), pick_code());
      end
    end
  endtask

  // Receiver: stall at random from the falling edge
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Scoreboard: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (torque_due.size() == 0) begin
        report_mismatch("result with nothing expected (torque)", 0,
                        $signed(m_tdata[TORQUE_BITS-1:0]));
      end else begin
        seen_want = torque_due.pop_front();
        if (m_tdata[TORQUE_BITS-1:0] !== seen_want.torque)
          report_mismatch("torque", $signed(seen_want.torque),
                          $signed(m_tdata[TORQUE_BITS-1:0]));
        if (m_tuser !== seen_want.calibrating)
          report_mismatch("calibrating", seen_want.calibrating, m_tuser);
      end
    end
  end

  initial begin
    int n_directed;
    int n_random;
    logic [GAIN_BITS-1:0] g;

    // Drive every input known from time zero and hold reset
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= FUNC_MEASURE;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    cals_ended     = 0;
    settings_applied = 0;

    // Predictor starts from the reset state
    foreach (win_slot[i]) win_slot[i] = '0;
    win_total  = '0;
    win_ptr    = '0;
    cal_offset = '0;
    cal_acc    = '0;
    cal_cnt    = '0;
    cal_on     = 1'b0;
    cfg_gain   = GAIN_RESET;
    cfg_negate = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, back to back
    foreach (plan[i])
      put_item(plan[i].op, plan[i].code, plan[i].typed, plan[i].torque, plan[i].cal);
    n_directed = items_sent;

    // Random phases; registers change only once the block has drained
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      g = phases[p].rand_gain ? GAIN_BITS'($urandom_range(65535)) : phases[p].gain;
      apply_settings(g, phases[p].negate);
      src_idle_pct   = phases[p].src_pct;
      sink_stall_pct = phases[p].sink_pct;
      run_random(PHASE_ITEMS);
    end
    n_random = items_sent - n_directed;

    // Wait out the queue, then watch for stray results
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += torque_due.size();

    $display("Sent %0d items: %0d directed, %0d random over %0d register settings;",
             items_sent, n_directed, n_random, settings_applied);
    $display("%0d calibrations ended, %0d results checked, %0d mismatches",
             cals_ended, results_seen, mismatches);
    if (mismatches == 0)
      $display("PASS torque_sensor_offset_calibrate_average");
    else
      $display("FAIL torque_sensor_offset_calibrate_average");
    $finish;
  end

endmodule
